@@ rtl/core/phta_pkg.sv @@
// ----------------------------------------------------------------------------
// phta_pkg: shared types and constants for the packet header timestamp assigner
// Field widths, queue sizing, register map and the decoded packet record.
// ----------------------------------------------------------------------------
package phta_pkg;

    // Field widths
    localparam int FB_W      = 8;
    localparam int WORD_W    = 56;
    localparam int PLEN_W    = 21;
    localparam int END_W     = 41;
    localparam int ENDV_W    = 40;
    localparam int TIME_W    = 64;
    localparam int FD_W      = 32;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 152;

    // Flag byte bits
    localparam int HDR_BIT = 0;
    localparam int KEY_BIT = 3;

    // Configuration map
    localparam int            APB_ADDR_W         = 3;
    localparam int            APB_DATA_W         = 32;
    localparam logic          REG_FRAME_DURATION = 1'b0;
    localparam logic [FD_W-1:0] FD_RESET         = 32'd400000;

    // Decoupling queue between the front and back parts
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Stored part of one packet
    typedef struct packed {
        logic              keyframe;
        logic [PLEN_W-1:0] payload;
        logic [WORD_W-1:0] duration;
    } phta_slot_t;

    // Decoded packet request handed from front to back
    typedef struct packed {
        logic              flush;
        logic [ENDV_W-1:0] end_val;
        phta_slot_t        slot;
    } phta_entry_t;

    // Queue status seen by its neighbors
    typedef struct packed {
        logic valid;
        logic full;
    } phta_qstat_t;

endpackage

@@ rtl/core/packet_header_timestamp_assigner.sv @@
// ----------------------------------------------------------------------------
// An accepted packet enters the queue in the next cycle; one request a cycle is
// taken while the four-entry queue has room. A flush first forms the start time
// from four partial products, then per result: read, two products, add, load.
// Reset (aresetn, sync, low): queue, counts, total, drop flag clear; fd = 400000.
// ----------------------------------------------------------------------------
// packet_header_timestamp_assigner: top level
// Stream input of packet headers, stream output of timed packets, APB
// register for the frame duration.
// ----------------------------------------------------------------------------
module packet_header_timestamp_assigner
    import phta_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] first_byte, [63:8] length_word, [84:64] packet_length,
    // [125:85] end_frame, [127:126] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] start_time, [127:64] stop_time, [148:128] payload_bytes,
    // [149] dropped, [151:150] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] keyframe
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic [FD_W-1:0] fd_reg;
    logic            cfg_wr;
    logic            push;
    logic            pop;
    phta_entry_t     push_entry;
    phta_entry_t     head_entry;
    phta_qstat_t     q_stat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_reg <= FD_RESET;
        end else if (cfg_wr && (paddr[2] == REG_FRAME_DURATION)) begin
            fd_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_DURATION) ? fd_reg : '0;

    phta_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (push_entry)
    );

    phta_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (push_entry),
        .pop     (pop),
        .rd_data (head_entry),
        .q_stat  (q_stat)
    );

    phta_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .frame_duration (fd_reg),
        .q_stat         (q_stat),
        .q_data         (head_entry),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

@@ rtl/core/phta_front.sv @@
// ----------------------------------------------------------------------------
// phta_front: input side of the timestamp assigner
// Accepts packet headers, drops header packets and decodes the rest into a
// packet record that is pushed into the queue.
// ----------------------------------------------------------------------------
module phta_front
    import phta_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  phta_qstat_t          q_stat,
    output logic                 push,
    output phta_entry_t          entry
);

    logic [FB_W-1:0]   first_byte;
    logic [WORD_W-1:0] length_word;
    logic [PLEN_W-1:0] packet_length;
    logic [END_W-1:0]  end_frame;
    logic [2:0]        nbytes;
    logic [3:0]        hsize;
    logic [PLEN_W-1:0] hsize_ext;

    assign first_byte    = s_tdata[7:0];
    assign length_word   = s_tdata[63:8];
    assign packet_length = s_tdata[84:64];
    assign end_frame     = s_tdata[125:85];

    // Request accepted whenever the queue has room; header packets vanish here
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready && !first_byte[HDR_BIT];

    // Length-byte count: bit 1 is the high bit, bits 7:6 the low two
    assign nbytes    = {first_byte[1], first_byte[7:6]};
    assign hsize     = {1'b0, nbytes} + 4'd1;
    assign hsize_ext = PLEN_W'(hsize);

    always_comb begin
        entry = '0;
        // Keep only the counted little-endian bytes
        for (int j = 0; j < WORD_W / 8; j++) begin
            if (3'(j) < nbytes) begin
                entry.slot.duration[8*j +: 8] = length_word[8*j +: 8];
            end
        end
        entry.slot.keyframe = first_byte[KEY_BIT];
        entry.slot.payload  = (packet_length > hsize_ext) ? (packet_length - hsize_ext)
                                                          : '0;
        // Positive end time triggers a flush
        entry.flush   = !end_frame[END_W-1] && (end_frame != '0);
        entry.end_val = end_frame[ENDV_W-1:0];
    end

endmodule

@@ rtl/core/phta_queue.sv @@
// ----------------------------------------------------------------------------
// phta_queue: short FIFO between the front and back parts
// Holds decoded packet records so either side can stall on its own.
// ----------------------------------------------------------------------------
module phta_queue
    import phta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  phta_entry_t wr_data,
    input  logic        pop,
    output phta_entry_t rd_data,
    output phta_qstat_t q_stat
);

    phta_entry_t        slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign q_stat.valid = (cnt_reg != '0);
    assign q_stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_data      = slots_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/phta_back.sv @@
// ----------------------------------------------------------------------------
// phta_back: execution side of the timestamp assigner
// Buffers packets in the store, keeps the frame total and, on a flush, works
// out start and stop times with a shared 32x32 multiplier, one result a time.
// ----------------------------------------------------------------------------
module phta_back
    import phta_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [FD_W-1:0]      frame_duration,
    input  phta_qstat_t          q_stat,
    input  phta_entry_t          q_data,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SWAIT = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EMUL  = 3'd4;
    localparam logic [2:0] ST_EWAIT = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Packet store
    phta_slot_t store_mem [STORE_DEPTH];
    phta_slot_t rd_slot_reg;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [TIME_W-1:0] total_reg, total_next;
    logic              drop_reg, drop_next;
    logic [ENDV_W-1:0] end_reg, end_next;
    logic [TIME_W-1:0] acc_reg, acc_next;
    logic [TIME_W-1:0] start_reg, start_next;

    // Multiplier pipeline
    logic [FD_W-1:0]   mul_a;
    logic [TIME_W-1:0] mul_full;
    logic [TIME_W-1:0] prod_reg;
    logic              pend_reg, pend_next;
    logic              pend_hi_reg, pend_neg_reg;
    logic [TIME_W-1:0] term;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_start_reg, out_stop_reg;
    logic              out_key_reg, out_drop_reg, out_last_reg;
    logic [PLEN_W-1:0] out_pay_reg;

    logic store_wr, store_room, is_last, out_load, issue;

    assign store_room = (count_reg < CNT_W'(STORE_DEPTH));
    assign pop        = (state_reg == ST_IDLE) && q_stat.valid;
    assign store_wr   = pop && store_room;
    assign is_last    = ((CNT_W'(rd_idx_reg) + 1'b1) == count_reg);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    assign issue      = (state_reg == ST_START) || (state_reg == ST_EMUL);

    // Multiplier operand for each step
    always_comb begin
        mul_a = '0;
        if (state_reg == ST_START) begin
            case (step_reg)
                2'd0:    mul_a = end_reg[31:0];
                2'd1:    mul_a = FD_W'(end_reg[ENDV_W-1:32]);
                2'd2:    mul_a = total_reg[31:0];
                2'd3:    mul_a = total_reg[63:32];
                default: mul_a = '0;
            endcase
        end else if (state_reg == ST_EMUL) begin
            mul_a = step_reg[0] ? FD_W'(rd_slot_reg.duration[WORD_W-1:32])
                                : rd_slot_reg.duration[31:0];
        end
    end

    assign mul_full = mul_a * frame_duration;
    assign term     = pend_hi_reg ? {prod_reg[31:0], 32'b0} : prod_reg;
    assign pend_next = issue;

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        total_next  = total_reg;
        drop_next   = drop_reg;
        end_next    = end_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;

        // Accumulate the partial product issued last cycle
        if (pend_reg) begin
            acc_next = pend_neg_reg ? acc_reg - term : acc_reg + term;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    total_next = total_reg + TIME_W'(q_data.slot.duration);
                    if (store_room) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (q_data.flush) begin
                        end_next    = q_data.end_val;
                        acc_next    = '0;
                        step_next   = '0;
                        rd_idx_next = '0;
                        state_next  = ST_START;
                    end
                end
            end
            ST_START: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3) begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                start_next = acc_reg;
                step_next  = '0;
                state_next = ST_EMUL;
            end
            ST_EMUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg[0]) begin
                    state_next = ST_EWAIT;
                end
            end
            ST_EWAIT: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    if (is_last) begin
                        count_next = '0;
                        total_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
            drop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            total_reg <= total_next;
            drop_reg  <= drop_next;
            pend_reg  <= pend_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        end_reg      <= end_next;
        acc_reg      <= acc_next;
        start_reg    <= start_next;
        prod_reg     <= mul_full;
        pend_hi_reg  <= step_reg[0];
        pend_neg_reg <= (state_reg == ST_START) && step_reg[1];
    end

    // Store write and registered read
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[count_reg[IDX_W-1:0]] <= q_data.slot;
        end
        rd_slot_reg <= store_mem[rd_idx_reg];
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_start_reg <= start_reg;
            out_stop_reg  <= acc_reg;
            out_key_reg   <= rd_slot_reg.keyframe;
            out_pay_reg   <= rd_slot_reg.payload;
            out_drop_reg  <= drop_reg;
            out_last_reg  <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_drop_reg, out_pay_reg, out_stop_reg, out_start_reg};
    assign m_tuser  = out_key_reg;
    assign m_tlast  = out_last_reg;

endmodule
